// ===== rtl/fmm_pkg.sv =====
// Shared types, constants and binary32 helper functions for the matrix multiply block.
// No dependencies; every other file of the block imports this package.
package fmm_pkg;

  // Store geometry and field widths.
  localparam int MaxDim  = 16;
  localparam int IdxW    = 4;
  localparam int AddrW   = 2 * IdxW;
  localparam int DimW    = 5;
  localparam int CfgIdxW = 2;
  localparam int FpW     = 32;

  // Default NaN pattern produced by invalid operations.
  localparam logic [FpW-1:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [FpW-1:0] QuietBit   = 32'h0040_0000;

  typedef enum logic [1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_ROW = 2'd1,
    STAT_COL = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_INNER  = 2'd1,
    CFG_COLS_B = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DISPATCH,
    CS_READ,
    CS_MUL0,
    CS_MUL1,
    CS_MUL2,
    CS_ADD0,
    CS_ADD1,
    CS_ADD2,
    CS_ADD3,
    CS_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load_item;
    logic            wr_mem;
    logic            clr_acc;
    logic            acc_en;
    logic            out_load;
    logic [DimW-1:0] k;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e             op;
    logic            ok;
    logic [DimW-1:0] kd;
  } dp_sts_t;

  // A dimension register above the store size acts as the store size.
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] d);
    return (d > DimW'(MaxDim)) ? DimW'(MaxDim) : d;
  endfunction

  // Row is checked before column.
  function automatic status_e check_bounds(input logic [IdxW-1:0] r, input logic [IdxW-1:0] c,
                                           input logic [DimW-1:0] nr,
                                           input logic [DimW-1:0] nc);
    status_e st;
    st = STAT_OK;
    if ({1'b0, r} >= nr) begin
      st = STAT_ROW;
    end else if ({1'b0, c} >= nc) begin
      st = STAT_COL;
    end
    return st;
  endfunction

  // Leading zero count of a 48-bit word; 48 for an all-zero word.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        n = 6'(47 - i);
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack. The mantissa has its leading one at bit 47
  // and the value is man/2^47 * 2^(exp-127). Tiny values are denormalized with
  // a sticky bit; large ones overflow to infinity.
  function automatic logic [FpW-1:0] round_pack(input logic sgn,
                                                input logic signed [10:0] exp,
                                                input logic [47:0] man);
    logic [47:0]        m;
    logic [47:0]        shr;
    logic [10:0]        sh;
    logic               inc;
    logic [24:0]        r;
    logic signed [10:0] e;
    logic signed [10:0] ev;
    logic [FpW-1:0]     res;
    if (exp >= 11'sd1) begin
      m = man;
      e = exp;
    end else begin
      sh  = 11'(11'sd1 - exp);
      shr = man >> sh;
      m   = shr | {47'b0, ((shr << sh) != man)};
      e   = 11'sd0;
    end
    inc = m[23] & ((|m[22:0]) | m[24]);
    r   = {1'b0, m[47:24]} + {24'b0, inc};
    if (e >= 11'sd1) begin
      ev = e + $signed({10'b0, r[24]});
      if (ev >= 11'sd255) begin
        res = {sgn, 8'hFF, 23'b0};
      end else begin
        res = {sgn, ev[7:0], r[22:0]};
      end
    end else begin
      res = {sgn, 7'b0, r[23], r[22:0]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/fmm_if.sv =====
// Valid/ready channel interfaces for items, results and configuration writes.
// Depends on fmm_pkg for field widths.
interface fmm_item_if import fmm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [IdxW-1:0]  row;
  logic [IdxW-1:0]  col;
  logic [FpW-1:0]   value;
  modport source (output valid, op, row, col, value, input ready);
  modport sink (input valid, op, row, col, value, output ready);
endinterface

interface fmm_result_if import fmm_pkg::*;;
  logic           valid;
  logic           ready;
  logic [FpW-1:0] product;
  logic [1:0]     status;
  modport source (output valid, product, status, input ready);
  modport sink (input valid, product, status, output ready);
endinterface

interface fmm_cfg_if import fmm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DimW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/float_matrix_multiply.sv =====
// A write, an error or an unused op passes from the item register through dispatch to the
// result register; a compute also walks one store read, three multiplier stages and four
// adder stages per inner index, one index at a time, before the result register is loaded.
// The block takes one item at a time; the next item is accepted the cycle after the result
// register is loaded, while that result may still wait. Reset is asynchronous, active
// low; it sets all dimensions to 1 and leaves the operand stores undefined until written.
module float_matrix_multiply import fmm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  fmm_cfg_if.sink         cfg_i,
  fmm_item_if.sink        item_i,
  fmm_result_if.source    result_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  fmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fmm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .in_op_i     (item_i.op),
    .in_row_i    (item_i.row),
    .in_col_i    (item_i.col),
    .in_value_i  (item_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .product_o   (result_o.product),
    .status_o    (result_o.status)
  );

endmodule

// ===== rtl/fmm_ctrl.sv =====
// Sequencing state machine of the matrix multiply block.
// Depends on fmm_pkg; drives the datapath through dp_cmd_t.
module fmm_ctrl import fmm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e     state_q, state_d;
  logic [DimW-1:0] k_q, k_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic [DimW-1:0] k_next;

  // State, inner index and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign k_next      = k_q + DimW'(1);
  assign in_ready_o  = (state_q == CS_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    cmd_o     = '0;
    cmd_o.k   = k_q;
    unique case (state_q)
      CS_IDLE: begin
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) begin
          state_d = CS_DISPATCH;
        end
      end
      CS_DISPATCH: begin
        cmd_o.clr_acc = 1'b1;
        k_d           = '0;
        if (sts_i.ok && (sts_i.op == OP_WR_A || sts_i.op == OP_WR_B)) begin
          cmd_o.wr_mem = 1'b1;
          state_d      = CS_DONE;
        end else if (sts_i.ok && sts_i.op == OP_COMPUTE && sts_i.kd != '0) begin
          state_d = CS_READ;
        end else begin
          state_d = CS_DONE;
        end
      end
      CS_READ: state_d = CS_MUL0;
      CS_MUL0: state_d = CS_MUL1;
      CS_MUL1: state_d = CS_MUL2;
      CS_MUL2: state_d = CS_ADD0;
      CS_ADD0: state_d = CS_ADD1;
      CS_ADD1: state_d = CS_ADD2;
      CS_ADD2: state_d = CS_ADD3;
      CS_ADD3: begin
        cmd_o.acc_en = 1'b1;
        k_d          = k_next;
        state_d      = (k_next == sts_i.kd) ? CS_DONE : CS_READ;
      end
      CS_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // The result register holds until the sink takes it.
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

endmodule

// ===== rtl/fmm_datapath.sv =====
// Datapath: dimension registers, operand stores, binary32 multiplier and adder.
// Depends on fmm_pkg; controlled by fmm_ctrl through dp_cmd_t.
module fmm_datapath import fmm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  input  logic [1:0]         in_op_i,
  input  logic [IdxW-1:0]    in_row_i,
  input  logic [IdxW-1:0]    in_col_i,
  input  logic [FpW-1:0]     in_value_i,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  output logic [FpW-1:0]     product_o,
  output logic [1:0]         status_o
);

  logic [DimW-1:0] rows_a_q, inner_q, cols_b_q;
  logic [DimW-1:0] ra, kd, cb;
  status_e         stat_in;
  op_e             op_q;
  status_e         stat_q;
  logic [IdxW-1:0] row_q, col_q;
  logic [FpW-1:0]  value_q;
  logic [FpW-1:0]  mem_a [MaxDim*MaxDim];
  logic [FpW-1:0]  mem_b [MaxDim*MaxDim];
  logic [FpW-1:0]  a_rd_q, b_rd_q;
  logic [IdxW-1:0] kidx;
  logic [FpW-1:0]  product_q;
  status_e         status_q;
  logic [FpW-1:0]  acc_q, acc_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DimW'(1);
      inner_q  <= DimW'(1);
      cols_b_q <= DimW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ROWS_A: rows_a_q <= cfg_data_i;
        CFG_INNER:  inner_q  <= cfg_data_i;
        CFG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ra = eff_dim(rows_a_q);
  assign kd = eff_dim(inner_q);
  assign cb = eff_dim(cols_b_q);

  // Bounds check of an arriving item.
  always_comb begin
    unique case (op_e'(in_op_i))
      OP_WR_A:    stat_in = check_bounds(in_row_i, in_col_i, ra, kd);
      OP_WR_B:    stat_in = check_bounds(in_row_i, in_col_i, kd, cb);
      OP_COMPUTE: stat_in = check_bounds(in_row_i, in_col_i, ra, cb);
      default:    stat_in = STAT_OK;
    endcase
  end

  // Item register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q    <= op_e'(in_op_i);
      row_q   <= in_row_i;
      col_q   <= in_col_i;
      value_q <= in_value_i;
      stat_q  <= stat_in;
    end
  end

  assign sts_o.op = op_q;
  assign sts_o.ok = (stat_q == STAT_OK);
  assign sts_o.kd = kd;

  // Operand stores: one write port, one registered read port each.
  assign kidx = cmd_i.k[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_mem && op_q == OP_WR_A) begin
      mem_a[{row_q, col_q}] <= value_q;
    end
    a_rd_q <= mem_a[{row_q, kidx}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_mem && op_q == OP_WR_B) begin
      mem_b[{row_q, col_q}] <= value_q;
    end
    b_rd_q <= mem_b[{kidx, col_q}];
  end

  // ---------------- Multiplier ----------------
  logic [7:0]         ma_e, mb_e, ma_ee, mb_ee;
  logic               ma_nan, mb_nan, ma_inf, mb_inf, ma_zero, mb_zero;
  logic               m_spec;
  logic [FpW-1:0]     m_sval;
  logic               m0_spec_q, m1_spec_q;
  logic [FpW-1:0]     m0_sval_q, m1_sval_q;
  logic               m0_sgn_q, m1_sgn_q;
  logic signed [10:0] m0_exp_q, m1_exp_q;
  logic [47:0]        m0_man_q, m1_man_q;
  logic [5:0]         m_lz;
  logic [FpW-1:0]     prod_q;

  assign ma_e    = a_rd_q[30:23];
  assign mb_e    = b_rd_q[30:23];
  assign ma_ee   = (ma_e == 8'd0) ? 8'd1 : ma_e;
  assign mb_ee   = (mb_e == 8'd0) ? 8'd1 : mb_e;
  assign ma_nan  = (&ma_e) && (|a_rd_q[22:0]);
  assign mb_nan  = (&mb_e) && (|b_rd_q[22:0]);
  assign ma_inf  = (&ma_e) && !(|a_rd_q[22:0]);
  assign mb_inf  = (&mb_e) && !(|b_rd_q[22:0]);
  assign ma_zero = (a_rd_q[30:0] == '0);
  assign mb_zero = (b_rd_q[30:0] == '0);

  // Special operands: NaN of the first operand wins, then the second.
  always_comb begin
    m_spec = 1'b1;
    if (ma_nan) begin
      m_sval = a_rd_q | QuietBit;
    end else if (mb_nan) begin
      m_sval = b_rd_q | QuietBit;
    end else if ((ma_inf && mb_zero) || (ma_zero && mb_inf)) begin
      m_sval = DefaultNan;
    end else if (ma_inf || mb_inf) begin
      m_sval = {a_rd_q[31] ^ b_rd_q[31], 8'hFF, 23'b0};
    end else if (ma_zero || mb_zero) begin
      m_sval = {a_rd_q[31] ^ b_rd_q[31], 31'b0};
    end else begin
      m_spec = 1'b0;
      m_sval = '0;
    end
  end

  // Stage 0: significand product and exponent sum.
  always_ff @(posedge clk_i) begin
    m0_spec_q <= m_spec;
    m0_sval_q <= m_sval;
    m0_sgn_q  <= a_rd_q[31] ^ b_rd_q[31];
    m0_exp_q  <= $signed({3'b0, ma_ee}) + $signed({3'b0, mb_ee}) - 11'sd126;
    m0_man_q  <= {24'b0, (ma_e != 8'd0), a_rd_q[22:0]} *
                 {24'b0, (mb_e != 8'd0), b_rd_q[22:0]};
  end

  // Stage 1: normalize.
  assign m_lz = lzc48(m0_man_q);

  always_ff @(posedge clk_i) begin
    m1_spec_q <= m0_spec_q;
    m1_sval_q <= m0_sval_q;
    m1_sgn_q  <= m0_sgn_q;
    m1_exp_q  <= m0_exp_q - $signed({5'b0, m_lz});
    m1_man_q  <= m0_man_q << m_lz;
  end

  // Stage 2: round into the product register.
  always_ff @(posedge clk_i) begin
    prod_q <= m1_spec_q ? m1_sval_q : round_pack(m1_sgn_q, m1_exp_q, m1_man_q);
  end

  // ---------------- Adder: acc + prod ----------------
  logic [7:0]         aa_e, ab_e;
  logic               aa_nan, ab_nan, aa_inf, ab_inf;
  logic               a_spec;
  logic [FpW-1:0]     a_sval;
  logic               swap;
  logic [FpW-1:0]     big, sml;
  logic [7:0]         big_ee, sml_ee, dexp;
  logic [26:0]        sml_ext, sml_sh;
  logic               a0_spec_q, a1_spec_q, a2_spec_q;
  logic [FpW-1:0]     a0_sval_q, a1_sval_q, a2_sval_q;
  logic               a0_sgn_q, a1_sgn_q, a2_sgn_q;
  logic               a0_sub_q, a1_sub_q, a2_sub_q;
  logic [7:0]         a0_exp_q, a1_exp_q;
  logic [26:0]        a0_big_q, a0_sml_q;
  logic [27:0]        a1_sum_q;
  logic               a2_zero_q;
  logic signed [10:0] a2_exp_q;
  logic [47:0]        a2_man_q;
  logic [47:0]        sum_w;
  logic [5:0]         a_lz;

  assign aa_e   = acc_q[30:23];
  assign ab_e   = prod_q[30:23];
  assign aa_nan = (&aa_e) && (|acc_q[22:0]);
  assign ab_nan = (&ab_e) && (|prod_q[22:0]);
  assign aa_inf = (&aa_e) && !(|acc_q[22:0]);
  assign ab_inf = (&ab_e) && !(|prod_q[22:0]);

  always_comb begin
    a_spec = 1'b1;
    if (aa_nan) begin
      a_sval = acc_q | QuietBit;
    end else if (ab_nan) begin
      a_sval = prod_q | QuietBit;
    end else if (aa_inf && ab_inf && (acc_q[31] != prod_q[31])) begin
      a_sval = DefaultNan;
    end else if (aa_inf) begin
      a_sval = acc_q;
    end else if (ab_inf) begin
      a_sval = prod_q;
    end else begin
      a_spec = 1'b0;
      a_sval = '0;
    end
  end

  // Stage 0: order by magnitude and align the smaller operand with sticky.
  assign swap    = (prod_q[30:0] > acc_q[30:0]);
  assign big     = swap ? prod_q : acc_q;
  assign sml     = swap ? acc_q : prod_q;
  assign big_ee  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
  assign sml_ee  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
  assign dexp    = big_ee - sml_ee;
  assign sml_ext = {(sml[30:23] != 8'd0), sml[22:0], 3'b0};
  assign sml_sh  = sml_ext >> dexp;

  always_ff @(posedge clk_i) begin
    a0_spec_q <= a_spec;
    a0_sval_q <= a_sval;
    a0_sgn_q  <= big[31];
    a0_sub_q  <= big[31] ^ sml[31];
    a0_exp_q  <= big_ee;
    a0_big_q  <= {(big[30:23] != 8'd0), big[22:0], 3'b0};
    a0_sml_q  <= sml_sh | {26'b0, ((sml_sh << dexp) != sml_ext)};
  end

  // Stage 1: add or subtract magnitudes.
  always_ff @(posedge clk_i) begin
    a1_spec_q <= a0_spec_q;
    a1_sval_q <= a0_sval_q;
    a1_sgn_q  <= a0_sgn_q;
    a1_sub_q  <= a0_sub_q;
    a1_exp_q  <= a0_exp_q;
    a1_sum_q  <= a0_sub_q ? ({1'b0, a0_big_q} - {1'b0, a0_sml_q})
                          : ({1'b0, a0_big_q} + {1'b0, a0_sml_q});
  end

  // Stage 2: normalize; bit 27 of the sum weighs 2^(exp-126).
  assign sum_w = {a1_sum_q, 20'b0};
  assign a_lz  = lzc48(sum_w);

  always_ff @(posedge clk_i) begin
    a2_spec_q <= a1_spec_q;
    a2_sval_q <= a1_sval_q;
    a2_sgn_q  <= a1_sgn_q;
    a2_sub_q  <= a1_sub_q;
    a2_zero_q <= (a1_sum_q == '0);
    a2_exp_q  <= $signed({3'b0, a1_exp_q}) + 11'sd1 - $signed({5'b0, a_lz});
    a2_man_q  <= sum_w << a_lz;
  end

  // Stage 3: round into the accumulator. An exact zero difference is +0.
  always_comb begin
    if (a2_spec_q) begin
      acc_d = a2_sval_q;
    end else if (a2_zero_q) begin
      acc_d = {a2_sgn_q & !a2_sub_q, 31'b0};
    end else begin
      acc_d = round_pack(a2_sgn_q, a2_exp_q, a2_man_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      product_q <= (op_q == OP_COMPUTE && stat_q == STAT_OK) ? acc_q : '0;
      status_q  <= stat_q;
    end
  end

  assign product_o = product_q;
  assign status_o  = status_q;

endmodule

// ===== rtl/fmm_checker.sv =====
// Port-level checks of the matrix multiply block, bound to the top level.
// Depends on fmm_pkg for status codes.
module fmm_checker import fmm_pkg::*; (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input logic [FpW-1:0] out_product_i,
  input logic [1:0]     out_status_i
);

  // A pending result stays until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // An error result carries a zero product.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != STAT_OK |-> out_product_i == '0)
    else $error("error result with nonzero product");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item accepted while one is in work");

  // A new result follows work on an item, never an idle input side.
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an item in work");

endmodule

bind float_matrix_multiply fmm_checker u_fmm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_product_i (result_o.product),
  .out_status_i  (result_o.status)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the binary32 matrix multiply block.
// Depends on fmm_pkg and the channel interfaces in rtl/fmm_if.sv.
module tb_top;
  import fmm_pkg::*;

  // Expected result of one item.
  typedef struct {
    logic [FpW-1:0] product;
    status_e        status;
  } elem_result_t;

  // Operand stores, dimensions and the queue of results still owed by the block.
  class matmul_scoreboard;
    logic [FpW-1:0] left_store[MaxDim*MaxDim];
    logic [FpW-1:0] right_store[MaxDim*MaxDim];
    bit             left_written[MaxDim*MaxDim];
    bit             right_written[MaxDim*MaxDim];
    logic [DimW-1:0] dims[3];
    elem_result_t   owed[$];
    int             errors;

    function void clear_dims();
      foreach (dims[i]) dims[i] = 1;
    endfunction

    function int unsigned clip(int idx);
      return (dims[idx] > MaxDim) ? MaxDim : dims[idx];
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Round m * 2^e to binary32, nearest even; m must be nonzero.
    function logic [FpW-1:0] round_bits(bit sgn, bit [63:0] m, int e);
      int          p;
      int          s;
      int          be;
      bit [63:0]   q;
      bit [63:0]   rem;
      bit [63:0]   half;
      p = 63;
      while (!m[p]) p--;
      s = p - 23;
      if (s < -149 - e) s = -149 - e;
      if (s <= 0) begin
        q = m << (-s);
      end else if (s >= 64) begin
        q = 0;
      end else begin
        q    = m >> s;
        rem  = m & ((64'd1 << s) - 1);
        half = 64'd1 << (s - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
      end
      be = s + e + 150;
      if (q[24]) begin
        q  = q >> 1;
        be = be + 1;
      end
      if (!q[23]) return {sgn, 8'd0, q[22:0]};
      if (be >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, be[7:0], q[22:0]};
    endfunction

    function bit is_nan(logic [FpW-1:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function bit is_inf(logic [FpW-1:0] x);
      return x[30:0] == {8'hFF, 23'd0};
    endfunction

    function logic [FpW-1:0] fmul(logic [FpW-1:0] a, logic [FpW-1:0] b);
      bit        sgn;
      bit [23:0] ma;
      bit [23:0] mb;
      int        ea;
      int        eb;
      sgn = a[31] ^ b[31];
      if (is_nan(a)) return a | QuietBit;
      if (is_nan(b)) return b | QuietBit;
      if (is_inf(a) || is_inf(b)) begin
        if (a[30:0] == 0 || b[30:0] == 0) return DefaultNan;
        return {sgn, 8'hFF, 23'd0};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'd0};
      ma = {a[30:23] != 0, a[22:0]};
      mb = {b[30:23] != 0, b[22:0]};
      ea = (a[30:23] == 0) ? 1 : a[30:23];
      eb = (b[30:23] == 0) ? 1 : b[30:23];
      return round_bits(sgn, 64'(ma) * 64'(mb), ea + eb - 300);
    endfunction

    function logic [FpW-1:0] fadd(logic [FpW-1:0] a, logic [FpW-1:0] b);
      logic [FpW-1:0] x;
      logic [FpW-1:0] y;
      bit [63:0]      mx;
      bit [63:0]      my;
      bit [63:0]      m1;
      bit [63:0]      m2;
      bit [63:0]      sum;
      int             ex;
      int             ey;
      int             d;
      if (is_nan(a)) return a | QuietBit;
      if (is_nan(b)) return b | QuietBit;
      if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? DefaultNan : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 0) return b;
      if (b[30:0] == 0) return a;
      // Order by magnitude so the larger operand sets the sign.
      if (a[30:0] >= b[30:0]) begin
        x = a;
        y = b;
      end else begin
        x = b;
        y = a;
      end
      mx = {x[30:23] != 0, x[22:0]};
      my = {y[30:23] != 0, y[22:0]};
      ex = (x[30:23] == 0) ? 1 : x[30:23];
      ey = (y[30:23] == 0) ? 1 : y[30:23];
      d  = ex - ey;
      m1 = mx << 30;
      if (d >= 54) begin
        m2 = 1;
      end else begin
        m2 = (my << 30) >> d;
        if ((m2 << d) != (my << 30)) m2 = m2 | 1;
      end
      sum = (x[31] == y[31]) ? m1 + m2 : m1 - m2;
      if (sum == 0) return 32'd0;
      return round_bits(x[31], sum, ex - 180);
    endfunction

    function status_e bounds(int r, int c, int nr, int nc);
      if (r >= nr) return STAT_ROW;
      if (c >= nc) return STAT_COL;
      return STAT_OK;
    endfunction

    // Works out the result of one accepted item and updates the stores.
    function void note_item(op_e op, int r, int c, logic [FpW-1:0] value);
      elem_result_t   res;
      logic [FpW-1:0] acc;
      int             ra;
      int             kd;
      int             cb;
      ra = clip(CFG_ROWS_A);
      kd = clip(CFG_INNER);
      cb = clip(CFG_COLS_B);
      res.product = 0;
      res.status  = STAT_OK;
      case (op)
        OP_WR_A: begin
          res.status = bounds(r, c, ra, kd);
          if (res.status == STAT_OK) begin
            left_store[r*MaxDim+c]   = value;
            left_written[r*MaxDim+c] = 1;
          end
        end
        OP_WR_B: begin
          res.status = bounds(r, c, kd, cb);
          if (res.status == STAT_OK) begin
            right_store[r*MaxDim+c]   = value;
            right_written[r*MaxDim+c] = 1;
          end
        end
        OP_COMPUTE: begin
          res.status = bounds(r, c, ra, cb);
          if (res.status == STAT_OK) begin
            acc = 0;
            for (int k = 0; k < kd; k++) begin
              acc = fadd(acc, fmul(left_store[r*MaxDim+k], right_store[k*MaxDim+c]));
            end
            res.product = acc;
          end
        end
        default: ;
      endcase
      owed.insert(owed.size(), res);
    endfunction

    // Compares one accepted result with the oldest one owed.
    function void check_result(logic [FpW-1:0] product, logic [1:0] status);
      elem_result_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: product %h status %0d", product, status);
        return;
      end
      want = owed.pop_front();
      if (product !== want.product || status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch: expected product %h status %0d, got product %h status %0d",
                   want.product, want.status, product, status);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   src_idle;
  int   snk_idle;
  int   random_sent;
  matmul_scoreboard sb;

  fmm_item_if   item_if ();
  fmm_result_if res_if ();
  fmm_cfg_if    cfg_if ();

  float_matrix_multiply dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_if),
    .item_i  (item_if),
    .result_o(res_if)
  );

  localparam int RandomItems = 700;
  localparam int Phases      = 7;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle);
  end

  // Watch both channels at every edge.
  always @(posedge clk) begin
    if (rst_n && item_if.valid && item_if.ready) begin
      sb.note_item(op_e'(item_if.op), item_if.row, item_if.col, item_if.value);
    end
    if (rst_n && res_if.valid && res_if.ready) begin
      sb.check_result(res_if.product, res_if.status);
    end
  end

  // Offers one item, idling first at random, and waits for it to be taken.
  task automatic send_item(op_e op, int r, int c, logic [FpW-1:0] value);
    while ($urandom_range(99) < src_idle) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.op    <= op;
    item_if.row   <= r[IdxW-1:0];
    item_if.col   <= c[IdxW-1:0];
    item_if.value <= value;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
  endtask

  // Holds the sender back until every owed result has come, plus the compute latency.
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3 + 8 * MaxDim) @(posedge clk);
  endtask

  // Offers one register write and waits for it to be taken; the caller drops valid.
  task automatic write_dim(cfg_reg_e idx, logic [DimW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.dims[idx] = data;
  endtask

  // Operand values: mostly moderate numbers, with specials and extremes mixed in.
  function automatic logic [FpW-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return {1'($urandom), 8'($urandom_range(134, 120)), 23'($urandom)};
    if (sel < 60) return $urandom;
    if (sel < 70) return {1'($urandom), 31'd0};
    if (sel < 78) return {1'($urandom), 8'd0, 23'($urandom)};
    if (sel < 85) return {1'($urandom), 8'hFF, 23'($urandom_range(1)) << $urandom_range(22)};
    if (sel < 92) return {1'($urandom), 8'($urandom_range(254, 200)), 23'($urandom)};
    return {1'($urandom), 8'($urandom_range(30, 1)), 23'($urandom)};
  endfunction

  function automatic int pick_index(int lim);
    if (lim > 0 && $urandom_range(99) < 80) return $urandom_range(lim - 1);
    return $urandom_range(MaxDim - 1);
  endfunction

  // One random item; a compute that would read an unwritten element writes it instead.
  task automatic send_random();
    int  sel;
    int  r;
    int  c;
    int  ra;
    int  kd;
    int  cb;
    bit  patched;
    ra  = sb.clip(CFG_ROWS_A);
    kd  = sb.clip(CFG_INNER);
    cb  = sb.clip(CFG_COLS_B);
    sel = $urandom_range(99);
    if (random_sent < RandomItems / 3) begin
      src_idle = 10;
      snk_idle = 63;
    end else if (random_sent < 2 * RandomItems / 3) begin
      src_idle = 63;
      snk_idle = 10;
    end else begin
      src_idle = 0;
      snk_idle = 0;
    end
    random_sent++;
    if (sel < 30) begin
      send_item(OP_WR_A, pick_index(ra), pick_index(kd), pick_value());
    end else if (sel < 60) begin
      send_item(OP_WR_B, pick_index(kd), pick_index(cb), pick_value());
    end else if (sel < 96) begin
      r = pick_index(ra);
      c = pick_index(cb);
      patched = 0;
      if (r < ra && c < cb) begin
        for (int k = 0; k < kd && !patched; k++) begin
          if (!sb.left_written[r*MaxDim+k]) begin
            send_item(OP_WR_A, r, k, pick_value());
            patched = 1;
          end else if (!sb.right_written[k*MaxDim+c]) begin
            send_item(OP_WR_B, k, c, pick_value());
            patched = 1;
          end
        end
      end
      if (!patched) send_item(OP_COMPUTE, r, c, pick_value());
    end else begin
      send_item(OP_NONE, $urandom_range(15), $urandom_range(15), $urandom);
    end
  endtask

  initial begin
    logic [DimW-1:0] settings[Phases][3];
    settings = '{'{16, 16, 16}, '{1, 16, 1}, '{16, 1, 16}, '{5, 31, 3},
                 '{0, 4, 2}, '{3, 0, 20}, '{2, 7, 9}};
    sb = new();
    sb.clear_dims();
    clk           = 1'b0;
    rst_n         = 1'b0;
    src_idle      = 0;
    snk_idle      = 0;
    random_sent   = 0;
    item_if.valid = 1'b0;
    item_if.op    = OP_NONE;
    item_if.row   = '0;
    item_if.col   = '0;
    item_if.value = '0;
    res_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_ROWS_A;
    cfg_if.data   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items with every dimension at its reset value of one.
    send_item(OP_WR_A, 0, 0, 32'h3F80_0000);
    send_item(OP_WR_B, 0, 0, 32'h4000_0000);
    send_item(OP_COMPUTE, 0, 0, 32'hFFFF_FFFF);
    send_item(OP_NONE, 15, 15, 32'hFFFF_FFFF);
    send_item(OP_WR_A, 1, 0, 32'h1234_5678);
    send_item(OP_WR_A, 0, 1, 32'h1234_5678);
    send_item(OP_WR_A, 15, 15, 32'h1234_5678);
    send_item(OP_WR_B, 0, 3, 32'h1234_5678);
    send_item(OP_WR_B, 2, 0, 32'h1234_5678);
    send_item(OP_COMPUTE, 0, 15, 32'h0);
    send_item(OP_COMPUTE, 15, 0, 32'h0);
    // Infinity times zero is invalid.
    send_item(OP_WR_A, 0, 0, 32'h7F80_0000);
    send_item(OP_WR_B, 0, 0, 32'h0000_0000);
    send_item(OP_COMPUTE, 0, 0, 32'h0);
    // A signaling NaN comes out quieted.
    send_item(OP_WR_A, 0, 0, 32'h7FA0_0001);
    send_item(OP_COMPUTE, 0, 0, 32'h0);
    // Overflow to infinity.
    send_item(OP_WR_A, 0, 0, 32'h7F7F_FFFF);
    send_item(OP_WR_B, 0, 0, 32'hFF7F_FFFF);
    send_item(OP_COMPUTE, 0, 0, 32'h0);
    // Half the smallest denormal ties to zero; a negative zero product sums to +0.
    send_item(OP_WR_A, 0, 0, 32'h0000_0001);
    send_item(OP_WR_B, 0, 0, 32'h3F00_0000);
    send_item(OP_COMPUTE, 0, 0, 32'h0);
    send_item(OP_WR_A, 0, 0, 32'h8000_0000);
    send_item(OP_COMPUTE, 0, 0, 32'h0);

    // Random phases, each under its own dimensions.
    for (int ph = 0; ph < Phases; ph++) begin
      drain();
      write_dim(CFG_ROWS_A, settings[ph][0]);
      write_dim(CFG_INNER, settings[ph][1]);
      write_dim(CFG_COLS_B, settings[ph][2]);
      cfg_if.valid <= 1'b0;
      for (int n = 0; n < RandomItems / Phases; n++) send_random();
    end

    item_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3 + 8 * MaxDim) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fmm_pkg.sv
rtl/fmm_if.sv
rtl/fmm_ctrl.sv
rtl/fmm_datapath.sv
rtl/float_matrix_multiply.sv
rtl/fmm_checker.sv
tb/tb_top.sv
